/* rtl/core/assert_macros.svh */
// ----------------------------------------------------------------------------
// Assertion macros
// Shared concurrent assertion forms, clocked on i_clk and held off in reset.
// ----------------------------------------------------------------------------
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Same-cycle implication.
`define LPHS_ASSERT_NOW(label, ant, cons, msg) \
    label: assert property (@(posedge i_clk) disable iff (!i_rst_n) \
        (ant) |-> (cons)) else $error(msg);

// Next-cycle implication.
`define LPHS_ASSERT_NEXT(label, ant, cons, msg) \
    label: assert property (@(posedge i_clk) disable iff (!i_rst_n) \
        (ant) |=> (cons)) else $error(msg);

`endif

/* rtl/core/lphs_pkg.sv */
// ----------------------------------------------------------------------------
// lphs_pkg
// Types, constants and hash step functions of the path string hash block.
// ----------------------------------------------------------------------------
package lphs_pkg;

    localparam int CHAR_W           = 8;
    localparam int HASH_W           = 32;
    localparam int LPHS_QUEUE_DEPTH = 4;

    localparam logic [CHAR_W-1:0] CH_QUOTE   = 8'h22;
    localparam logic [CHAR_W-1:0] CH_BSLASH  = 8'h5C;
    localparam logic [CHAR_W-1:0] CH_SLASH   = 8'h2F;
    localparam logic [CHAR_W-1:0] CH_UPPER_A = 8'h41;
    localparam logic [CHAR_W-1:0] CH_UPPER_Z = 8'h5A;
    localparam logic [CHAR_W-1:0] CH_NUL     = 8'h00;
    localparam logic [CHAR_W-1:0] CASE_OFS   = 8'd32;

    // One queued operation for the hash engine.
    typedef struct packed {
        logic              is_final;  // finalize and emit instead of mixing
        logic              use_seed;  // start from the seed, not the running hash
        logic              load_only; // take the start value without mixing a byte
        logic [CHAR_W-1:0] char_b;    // folded byte (mix only)
    } t_op;

    typedef struct packed {
        logic at_first;
        logic quoted;
        logic stopped;
        logic mixed;
    } t_front_status;

    // Case fold to lowercase and turn backslash into slash.
    function automatic logic [CHAR_W-1:0] fold_byte(input logic [CHAR_W-1:0] b);
        logic [CHAR_W-1:0] r;
        r = b;
        if (b >= CH_UPPER_A && b <= CH_UPPER_Z) begin
            r = b + CASE_OFS;
        end else if (b == CH_BSLASH) begin
            r = CH_SLASH;
        end
        return r;
    endfunction

    // h = (h + sext(b)) * 1025; h ^= h >> 6
    function automatic logic [HASH_W-1:0] mix_step(input logic [HASH_W-1:0] h,
                                                   input logic [CHAR_W-1:0] b);
        logic [HASH_W-1:0] x;
        logic [HASH_W-1:0] t;
        x = h + {{(HASH_W-CHAR_W){b[CHAR_W-1]}}, b};
        t = x + (x << 10);
        return t ^ (t >> 6);
    endfunction

    // h *= 9; h ^= h >> 11; h *= 32769
    function automatic logic [HASH_W-1:0] finalize(input logic [HASH_W-1:0] h);
        logic [HASH_W-1:0] t;
        logic [HASH_W-1:0] u;
        t = h + (h << 3);
        u = t ^ (t >> 11);
        return u + (u << 15);
    endfunction

endpackage

/* rtl/core/lphs_if.sv */
// ----------------------------------------------------------------------------
// lphs channel interfaces
// Valid/ready channels for input bytes and for finished hash words.
// ----------------------------------------------------------------------------
interface lphs_in_if;
    import lphs_pkg::*;
    logic              valid;
    logic              ready;
    logic [CHAR_W-1:0] char_byte;
    logic              end_of_string;

    modport source (output valid, output char_byte, output end_of_string, input ready);
    modport sink   (input valid, input char_byte, input end_of_string, output ready);
endinterface

interface lphs_out_if;
    import lphs_pkg::*;
    logic              valid;
    logic              ready;
    logic [HASH_W-1:0] hash_value;

    modport source (output valid, output hash_value, input ready);
    modport sink   (input valid, input hash_value, output ready);
endinterface

/* rtl/core/lphs_front.sv */
// ----------------------------------------------------------------------------
// lphs_front
// Accepts input words, tracks string position and quoting, and queues ops.
// ----------------------------------------------------------------------------
module lphs_front (
    input  logic                  i_clk,
    input  logic                  i_rst_n,
    lphs_in_if.sink               i_in,
    input  logic                  i_room,
    output logic                  o_push,
    output lphs_pkg::t_op         o_push_op,
    output lphs_pkg::t_front_status o_status
);
    import lphs_pkg::*;

    logic r_at_first, r_quoted, r_stopped, r_mixed;
    logic n_at_first, n_quoted, n_stopped, n_mixed;
    logic accept;

    assign i_in.ready = i_room;
    assign accept     = i_in.valid && i_room;

    always_comb begin
        n_at_first          = r_at_first;
        n_quoted            = r_quoted;
        n_stopped           = r_stopped;
        n_mixed             = r_mixed;
        o_push              = 1'b0;
        o_push_op.is_final  = i_in.end_of_string;
        o_push_op.use_seed  = !r_mixed;
        o_push_op.load_only = 1'b0;
        o_push_op.char_b    = fold_byte(i_in.char_byte);
        if (accept) begin
            if (i_in.end_of_string) begin
                o_push     = 1'b1;
                n_at_first = 1'b1;
                n_quoted   = 1'b0;
                n_stopped  = 1'b0;
                n_mixed    = 1'b0;
            end else if (r_at_first && i_in.char_byte == CH_QUOTE) begin
                // A leading quote opens quoted mode and is not hashed. The
                // string still takes its start value from the seed, through a load op.
                o_push              = 1'b1;
                o_push_op.load_only = 1'b1;
                n_at_first          = 1'b0;
                n_quoted            = 1'b1;
                n_mixed             = 1'b1;
            end else begin
                n_at_first = 1'b0;
                if (!r_stopped) begin
                    if (i_in.char_byte == CH_NUL ||
                        (r_quoted && i_in.char_byte == CH_QUOTE)) begin
                        n_stopped = 1'b1;
                        // A zero first byte still fixes the start value.
                        if (r_at_first) begin
                            o_push              = 1'b1;
                            o_push_op.load_only = 1'b1;
                            n_mixed             = 1'b1;
                        end
                    end else begin
                        o_push  = 1'b1;
                        n_mixed = 1'b1;
                    end
                end
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_at_first <= 1'b1;
            r_quoted   <= 1'b0;
            r_stopped  <= 1'b0;
            r_mixed    <= 1'b0;
        end else begin
            r_at_first <= n_at_first;
            r_quoted   <= n_quoted;
            r_stopped  <= n_stopped;
            r_mixed    <= n_mixed;
        end
    end

    assign o_status = '{at_first: r_at_first, quoted: r_quoted,
                        stopped: r_stopped, mixed: r_mixed};

endmodule

/* rtl/core/lphs_queue.sv */
// ----------------------------------------------------------------------------
// lphs_queue
// Small register FIFO of hash ops between the front and the hash engine.
// ----------------------------------------------------------------------------
module lphs_queue #(
    parameter int DEPTH = lphs_pkg::LPHS_QUEUE_DEPTH
) (
    input  logic                          i_clk,
    input  logic                          i_rst_n,
    input  logic                          i_push,
    input  lphs_pkg::t_op                 i_push_op,
    input  logic                          i_pop,
    output lphs_pkg::t_op                 o_pop_op,
    output logic                          o_full,
    output logic                          o_empty,
    output logic [$clog2(DEPTH+1)-1:0]    o_count
);
    import lphs_pkg::*;

    localparam int IDX_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int CNT_W = $clog2(DEPTH+1);
    localparam logic [IDX_W-1:0] LAST = IDX_W'(DEPTH-1);

    t_op              r_mem [DEPTH];
    logic [IDX_W-1:0] r_wr, r_rd;
    logic [CNT_W-1:0] r_count;
    logic             do_push, do_pop;

    assign o_full   = (r_count == CNT_W'(DEPTH));
    assign o_empty  = (r_count == '0);
    assign o_count  = r_count;
    assign o_pop_op = r_mem[r_rd];
    assign do_push  = i_push && !o_full;
    assign do_pop   = i_pop && !o_empty;

    always_ff @(posedge i_clk) begin
        if (do_push) begin
            r_mem[r_wr] <= i_push_op;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr    <= '0;
            r_rd    <= '0;
            r_count <= '0;
        end else begin
            if (do_push) begin
                r_wr <= (r_wr == LAST) ? '0 : r_wr + 1'b1;
            end
            if (do_pop) begin
                r_rd <= (r_rd == LAST) ? '0 : r_rd + 1'b1;
            end
            if (do_push && !do_pop) begin
                r_count <= r_count + 1'b1;
            end else if (do_pop && !do_push) begin
                r_count <= r_count - 1'b1;
            end
        end
    end

endmodule

/* rtl/core/lphs_back.sv */
// ----------------------------------------------------------------------------
// lphs_back
// Hash engine: loads start values, mixes queued bytes and finalizes into a registered output.
// ----------------------------------------------------------------------------
module lphs_back (
    input  logic                        i_clk,
    input  logic                        i_rst_n,
    input  logic [lphs_pkg::HASH_W-1:0] i_seed,
    input  logic                        i_op_valid,
    input  lphs_pkg::t_op               i_op,
    output logic                        o_pop,
    lphs_out_if.source                  o_out
);
    import lphs_pkg::*;

    logic [HASH_W-1:0] r_hash;
    logic [HASH_W-1:0] r_out_hash;
    logic              r_out_valid;
    logic [HASH_W-1:0] base;
    logic              out_free;

    assign base     = i_op.use_seed ? i_seed : r_hash;
    assign out_free = !r_out_valid || o_out.ready;
    // Mix and load ops never wait; a final op waits for the output register.
    assign o_pop    = i_op_valid && (!i_op.is_final || out_free);

    always_ff @(posedge i_clk) begin
        if (o_pop && !i_op.is_final) begin
            r_hash <= i_op.load_only ? base : mix_step(base, i_op.char_b);
        end
        if (o_pop && i_op.is_final) begin
            r_out_hash <= finalize(base);
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (o_pop && i_op.is_final) begin
            r_out_valid <= 1'b1;
        end else if (o_out.ready) begin
            r_out_valid <= 1'b0;
        end
    end

    assign o_out.valid      = r_out_valid;
    assign o_out.hash_value = r_out_hash;

endmodule

/* rtl/core/lowercase_path_string_hash.sv */
// A terminator word's op passes through the op queue, then is finalized into the output register.
// Throughput: one input word per cycle while the op queue has room; the op queue and output register set this.
// A full op queue (QUEUE_DEPTH entries) holds off input while the output stalls.
// Reset (i_rst_n, synchronous, active low) clears the seed to zero, empties the
// queue, drops any pending hash word and returns the string tracker to string start.
// ----------------------------------------------------------------------------
// lowercase_path_string_hash
// Seeded one-at-a-time hash of case-folded path strings, one byte per word.
// ----------------------------------------------------------------------------
`include "assert_macros.svh"

module lowercase_path_string_hash #(
    parameter int QUEUE_DEPTH = lphs_pkg::LPHS_QUEUE_DEPTH
) (
    input  logic                        i_clk,
    input  logic                        i_rst_n,
    input  logic                        i_cfg_we,
    input  logic [lphs_pkg::HASH_W-1:0] i_cfg_wdata,
    lphs_in_if.sink                     i_in,
    lphs_out_if.source                  o_out
);
    import lphs_pkg::*;

    localparam int CNT_W = $clog2(QUEUE_DEPTH+1);

    // Seed register; the hash engine reads it when the op of a string's first
    // byte or the finalize of an empty string executes. The user must write it
    // only while the block is idle; the block does not enforce this. Then the
    // value seen there matches the one current when the word arrived.
    logic [HASH_W-1:0] r_seed;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_seed <= '0;
        end else if (i_cfg_we) begin
            r_seed <= i_cfg_wdata;
        end
    end

    logic          push, pop, q_full, q_empty;
    t_op           push_op, pop_op;
    t_front_status front_st;
    logic [CNT_W-1:0] q_count;

    // Front: decides per word whether it loads the seed, mixes, finalizes or
    // is dropped (bytes after a closing quote or a NUL). The first byte of a
    // string always queues an op, so the start value is fixed at that byte.
    lphs_front u_front (
        .i_clk     (i_clk),
        .i_rst_n   (i_rst_n),
        .i_in      (i_in),
        .i_room    (!q_full),
        .o_push    (push),
        .o_push_op (push_op),
        .o_status  (front_st)
    );

    // Op queue decoupling the front from a stalled output.
    lphs_queue #(
        .DEPTH (QUEUE_DEPTH)
    ) u_queue (
        .i_clk     (i_clk),
        .i_rst_n   (i_rst_n),
        .i_push    (push),
        .i_push_op (push_op),
        .i_pop     (pop),
        .o_pop_op  (pop_op),
        .o_full    (q_full),
        .o_empty   (q_empty),
        .o_count   (q_count)
    );

    // Back: one load, one mix or one finalize per cycle; a finalize waits while the output holds an untaken hash word.
    lphs_back u_back (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_seed     (r_seed),
        .i_op_valid (!q_empty),
        .i_op       (pop_op),
        .o_pop      (pop),
        .o_out      (o_out)
    );

    // A terminator always sends the tracker back to string start.
    `LPHS_ASSERT_NEXT(a_eos_restart, i_in.valid && i_in.ready && i_in.end_of_string, front_st.at_first && !front_st.stopped && !front_st.mixed && !front_st.quoted, "tracker not reset after terminator")
    // The queue count never passes its depth.
    `LPHS_ASSERT_NOW(a_queue_bound, 1'b1, q_count <= CNT_W'(QUEUE_DEPTH), "op queue overflow")
    // A hash word can only appear after an op was waiting in the queue.
    `LPHS_ASSERT_NOW(a_out_from_queue, $rose(o_out.valid), $past(!q_empty), "hash word without a queued op")

endmodule

/* sim/tb_lowercase_path_string_hash.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb_lowercase_path_string_hash
// Self-checking bench for the seeded, case-folding path string hash. Byte
// words are driven over the input channel with random gaps. An independent
// model predicts each finished hash word, and a scoreboard compares it with
// what leaves the output channel under random back-pressure.
// ----------------------------------------------------------------------------
module tb_lowercase_path_string_hash;
    import lphs_pkg::*;

    // Tracks the hash of the string in flight and holds the finished hash
    // words that are still owed by the block, oldest first.
    class hash_scoreboard;
        logic [HASH_W-1:0] seed_reg;
        logic [HASH_W-1:0] run_hash;
        bit                at_first;
        bit                quoted;
        bit                halted;
        logic [HASH_W-1:0] owed_hashes[$];
        int                mismatches;

        function new();
            seed_reg   = '0;
            mismatches = 0;
            restart();
        endfunction

        function void restart();
            run_hash = seed_reg;
            at_first = 1'b1;
            quoted   = 1'b0;
            halted   = 1'b0;
        endfunction

        function void set_seed(logic [HASH_W-1:0] value);
            seed_reg = value;
        endfunction

        // Lowercase, slash-normalize and sign-extend one byte, then mix it in.
        function logic [HASH_W-1:0] mix_char(logic [HASH_W-1:0] h, logic [CHAR_W-1:0] ch);
            logic [CHAR_W-1:0] f;
            logic [HASH_W-1:0] t;
            f = ch;
            if (ch >= CH_UPPER_A && ch <= CH_UPPER_Z) begin
                f = ch + 8'd32;
            end else if (ch == CH_BSLASH) begin
                f = CH_SLASH;
            end
            t = (h + {{(HASH_W-CHAR_W){f[CHAR_W-1]}}, f}) * 32'd1025;
            return t ^ (t >> 6);
        endfunction

        function logic [HASH_W-1:0] avalanche(logic [HASH_W-1:0] h);
            logic [HASH_W-1:0] t;
            t = h * 32'd9;
            t = t ^ (t >> 11);
            return t * 32'd32769;
        endfunction

        function void note_word(logic [CHAR_W-1:0] ch, logic eos);
            if (eos) begin
                owed_hashes = {owed_hashes, avalanche(at_first ? seed_reg : run_hash)};
                restart();
                return;
            end
            // The seed is latched by the first byte, not by the previous terminator.
            if (at_first) begin
                run_hash = seed_reg;
                at_first = 1'b0;
                if (ch == CH_QUOTE) begin
                    quoted = 1'b1;
                    return;
                end
            end
            if (halted) begin
                return;
            end
            if (ch == CH_NUL || (quoted && ch == CH_QUOTE)) begin
                halted = 1'b1;
                return;
            end
            run_hash = mix_char(run_hash, ch);
        endfunction

        function void report(string what, logic [HASH_W-1:0] want, logic [HASH_W-1:0] got);
            mismatches++;
            if (mismatches <= 10) begin
                $display("%0t: %s: expected %08h, got %08h", $realtime, what, want, got);
            end
        endfunction

        function void check_hash(logic [HASH_W-1:0] got);
            logic [HASH_W-1:0] want;
            if (owed_hashes.size() == 0) begin
                report("hash word with none owed", '0, got);
                return;
            end
            want = owed_hashes.pop_front();
            if (got !== want) begin
                report("hash_value", want, got);
            end
        endfunction

        function int outstanding();
            return owed_hashes.size();
        endfunction
    endclass

    // Cycles without any handshake or register write before the run is
    // declared hung. The limit lies far beyond the longest gap, stall or drain
    // of a correct run.
    localparam int WATCHDOG_LIMIT = 4000;
    // Extra cycles after the last owed word, and before every seed write,
    // so that bytes still queued inside the block have been consumed.
    localparam int SETTLE_CYCLES  = LPHS_QUEUE_DEPTH + 12;
    localparam int PHASES         = 6;
    localparam int PHASE_WORDS    = 205;

    logic              i_clk;
    logic              i_rst_n;
    logic              i_cfg_we;
    logic [HASH_W-1:0] i_cfg_wdata;

    lphs_in_if  in_if ();
    lphs_out_if out_if ();

    lowercase_path_string_hash dut (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_cfg_we    (i_cfg_we),
        .i_cfg_wdata (i_cfg_wdata),
        .i_in        (in_if),
        .o_out       (out_if)
    );

    hash_scoreboard sb = new();

    int words_sent;
    int stall_cycles;
    // When set, both sides run flat out: no gaps and no new stalls start.
    bit no_idle;

    initial begin
        i_clk = 1'b0;
        forever begin
            #5 i_clk = ~i_clk;
        end
    end

    // Everything the block does is observed at the rising edge. The inputs
    // only move at falling edges, so the sampled values are settled.
    always @(posedge i_clk) begin
        if (i_rst_n) begin
            if (i_cfg_we) begin
                sb.set_seed(i_cfg_wdata);
            end
            if (in_if.valid && in_if.ready) begin
                sb.note_word(in_if.char_byte, in_if.end_of_string);
            end
            if (out_if.valid && out_if.ready) begin
                sb.check_hash(out_if.hash_value);
            end
        end
    end

    // Watchdog: counts consecutive cycles in which nothing moves.
    always @(posedge i_clk) begin
        if (!i_rst_n || i_cfg_we || (in_if.valid && in_if.ready)
                || (out_if.valid && out_if.ready)) begin
            stall_cycles <= 0;
        end else begin
            stall_cycles <= stall_cycles + 1;
        end
    end

    initial begin
        stall_cycles = 0;
        wait (stall_cycles >= WATCHDOG_LIMIT);
        $display("SCOREBOARD MISMATCH");
        $finish;
    end

    // Mostly short gaps, now and then a long one.
    function automatic int choose_gap();
        if ($urandom_range(0, 99) < 85) begin
            return $urandom_range(1, 3);
        end
        return $urandom_range(8, 40);
    endfunction

    // Output back-pressure. Stalls start at random on any cycle, so they
    // land on every phase of the block's work, except in no-idle stretches.
    initial begin
        int stall_left;
        stall_left   = 0;
        out_if.ready = 1'b0;
        wait (i_rst_n === 1'b1);
        forever begin
            @(negedge i_clk);
            if (stall_left > 0) begin
                out_if.ready = 1'b0;
                stall_left--;
            end else begin
                out_if.ready = 1'b1;
                if (!no_idle && $urandom_range(0, 99) < 20) begin
                    stall_left = choose_gap();
                end
            end
        end
    end

    // Presents one byte word, optionally after a gap, and returns at the
    // rising edge where it is taken. Valid stays high when the next word
    // follows with no gap.
    task automatic send_word(input logic [CHAR_W-1:0] ch, input logic eos);
        int gap;
        gap = 0;
        if (!no_idle && $urandom_range(0, 99) < 35) begin
            gap = choose_gap();
        end
        @(negedge i_clk);
        repeat (gap) begin
            in_if.valid         = 1'b0;
            in_if.char_byte     = CHAR_W'($urandom_range(0, 255));
            in_if.end_of_string = 1'($urandom_range(0, 1));
            @(negedge i_clk);
        end
        in_if.valid         = 1'b1;
        in_if.char_byte     = ch;
        in_if.end_of_string = eos;
        @(posedge i_clk);
        while (!in_if.ready) begin
            @(posedge i_clk);
        end
        words_sent++;
    endtask

    // Drops valid and waits until every owed hash word is out and the block
    // has had time to use up any bytes it still holds.
    task automatic drain();
        @(negedge i_clk);
        in_if.valid = 1'b0;
        while (sb.outstanding() != 0) begin
            @(negedge i_clk);
        end
        repeat (SETTLE_CYCLES) @(negedge i_clk);
    endtask

    // Seed writes happen only with the block drained.
    task automatic write_seed(input logic [HASH_W-1:0] value);
        drain();
        i_cfg_we    = 1'b1;
        i_cfg_wdata = value;
        @(negedge i_clk);
        i_cfg_we    = 1'b0;
        i_cfg_wdata = $urandom();
    endtask

    // Path-like characters, weighted toward the ones the fold rules touch.
    function automatic logic [CHAR_W-1:0] pick_char();
        int r;
        r = $urandom_range(0, 99);
        if (r < 28) return CHAR_W'($urandom_range(CH_UPPER_A, CH_UPPER_Z));
        if (r < 52) return CHAR_W'($urandom_range(8'h61, 8'h7A));
        if (r < 62) return CH_BSLASH;
        if (r < 69) return CH_SLASH;
        if (r < 74) return 8'h2E;
        if (r < 77) return CH_NUL;
        if (r < 81) return CH_QUOTE;
        return CHAR_W'($urandom_range(0, 255));
    endfunction

    // One random string with its terminator: plain path text most of the
    // time, sometimes a quoted one, sometimes raw noise with stray
    // terminators mixed in.
    task automatic send_random_string();
        int kind;
        int len;
        int close_at;
        no_idle = ($urandom_range(0, 4) == 0);
        kind    = $urandom_range(0, 99);
        len     = ($urandom_range(0, 19) == 0) ? $urandom_range(20, 40) : $urandom_range(0, 10);
        if (kind < 10) begin
            for (int i = 0; i < len; i++) begin
                send_word(CHAR_W'($urandom_range(0, 255)), $urandom_range(0, 7) == 0);
            end
        end else if (kind < 32) begin
            send_word(CH_QUOTE, 1'b0);
            close_at = $urandom_range(0, len);
            for (int i = 0; i < len; i++) begin
                send_word((i == close_at) ? CH_QUOTE : pick_char(), 1'b0);
            end
        end else begin
            for (int i = 0; i < len; i++) begin
                send_word(pick_char(), 1'b0);
            end
        end
        // The terminator's byte is don't-care, so it gets a random one.
        send_word(CHAR_W'($urandom_range(0, 255)), 1'b1);
    endtask

    initial begin
        logic [HASH_W-1:0] phase_seeds[PHASES];

        i_rst_n             = 1'b0;
        i_cfg_we            = 1'b0;
        i_cfg_wdata         = '0;
        in_if.valid         = 1'b0;
        in_if.char_byte     = '0;
        in_if.end_of_string = 1'b0;
        words_sent          = 0;
        no_idle             = 1'b0;

        // Synchronous reset held over rising edges, released at a falling edge.
        repeat (2) @(posedge i_clk);
        @(negedge i_clk);
        i_rst_n = 1'b1;

        // Directed part, under the seed of zero left by reset.
        // Empty strings: a terminator straight away gives the finalized
        // seed, twice in a row, with a byte that must be ignored.
        send_word(8'hFF, 1'b1);
        send_word(8'h00, 1'b1);
        // Both ends of A-Z and their neighbors, backslash, lowercase, and
        // the sign boundary of the byte.
        send_word(CH_UPPER_A, 1'b0);
        send_word(CH_UPPER_Z, 1'b0);
        send_word(8'h40, 1'b0);
        send_word(8'h5B, 1'b0);
        send_word(CH_BSLASH, 1'b0);
        send_word(8'h61, 1'b0);
        send_word(8'h7A, 1'b0);
        send_word(8'h7F, 1'b0);
        send_word(8'h80, 1'b0);
        send_word(8'hFF, 1'b0);
        send_word(8'h01, 1'b0);
        send_word(8'h00, 1'b1);
        // A zero byte ends the content; what follows it is ignored.
        send_word(8'h70, 1'b0);
        send_word(CH_NUL, 1'b0);
        send_word(8'h71, 1'b0);
        send_word(8'h00, 1'b1);
        // Leading quote: skipped, and the closing quote stops hashing.
        send_word(CH_QUOTE, 1'b0);
        send_word(8'h78, 1'b0);
        send_word(CH_QUOTE, 1'b0);
        send_word(8'h79, 1'b0);
        send_word(8'h00, 1'b1);
        // A quote that is not the first byte is hashed like any other byte.
        send_word(8'h71, 1'b0);
        send_word(CH_QUOTE, 1'b0);
        send_word(8'h72, 1'b0);
        send_word(8'h00, 1'b1);
        // A lone opening quote, then the terminator.
        send_word(CH_QUOTE, 1'b0);
        send_word(8'h22, 1'b1);

        // Random part, one seed per phase with the extremes among them.
        phase_seeds[0] = 32'hFFFF_FFFF;
        phase_seeds[1] = 32'h0000_0000;
        phase_seeds[2] = $urandom();
        phase_seeds[3] = 32'h8000_0000;
        phase_seeds[4] = $urandom();
        phase_seeds[5] = 32'h0000_0001;
        for (int p = 0; p < PHASES; p++) begin
            write_seed(phase_seeds[p]);
            words_sent = 0;
            while (words_sent < PHASE_WORDS) begin
                send_random_string();
            end
            // Odd phases leave a string open, so the next seed is written
            // mid-string and must only apply from the next string start.
            if (p % 2 == 1) begin
                send_word(pick_char(), 1'b0);
                send_word(pick_char(), 1'b0);
            end
        end
        no_idle = 1'b0;
        send_word(pick_char(), 1'b1);

        // All stimulus is in: wait for the owed words, then SETTLE_CYCLES more
        // to catch anything extra the block might still emit.
        drain();
        if (sb.mismatches == 0 && sb.outstanding() == 0) begin
            $display("SCOREBOARD CLEAN");
        end else begin
            $display("SCOREBOARD MISMATCH");
        end
        $finish;
    end

endmodule

/* files.f */
+incdir+rtl/core
rtl/core/lphs_pkg.sv
rtl/core/lphs_if.sv
rtl/core/lphs_front.sv
rtl/core/lphs_queue.sv
rtl/core/lphs_back.sv
rtl/core/lowercase_path_string_hash.sv
sim/tb_lowercase_path_string_hash.sv
